### rtl/core/pdftx_pkg.sv
// ----------------------------------------------------------------------------
// pdftx_pkg
// Shared types, character codes and parser mode codes for the PDF text
// operator extractor.
// ----------------------------------------------------------------------------
package pdftx_pkg;

  // Parser modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_LT   = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_LIT  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [15:0] KERN_THRESHOLD_RST = 16'd120;
  localparam logic [16:0] INT_SAT            = 17'd65536;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Up to two text bytes produced by one input byte
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] b1;
    logic [7:0] b0;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c[3:0] + 4'd9)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

endpackage

### rtl/core/pdftx_parser.sv
// ----------------------------------------------------------------------------
// pdftx_parser
// Parser state registers and the single-pass byte decoder; emits up to two
// text bytes for each accepted request.
// ----------------------------------------------------------------------------
module pdftx_parser #(
  parameter int unsigned MaxNestDepth = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       in_byte_i,
  input  logic             stream_end_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output pdftx_pkg::push_t push_o
);
  import pdftx_pkg::*;

  localparam int unsigned NW = $clog2(MaxNestDepth + 1);
  localparam logic [NW-1:0] NEST_MAX = NW'(MaxNestDepth);
  localparam logic [NW-1:0] NEST_ONE = NW'(1);

  logic [15:0]   kern_thr_q;
  logic [1:0]    mode_q, mode_d, mode_n;
  logic          in_arr_q, in_arr_d, in_arr_n;
  logic [NW-1:0] nest_q, nest_d, nest_n;
  logic          esc_q, esc_d, esc_n;
  logic [1:0]    oc_q, oc_d, oc_n;
  logic [7:0]    ov_q, ov_d, ov_n;
  logic          hv_q, hv_d, hv_n;
  logic [3:0]    hn_q, hn_d, hn_n;
  logic          nf_act_q, nf_act_d, nf_act_n;
  logic          nf_neg_q, nf_neg_d, nf_neg_n;
  logic          nf_dot_q, nf_dot_d, nf_dot_n;
  logic          nf_frac_q, nf_frac_d, nf_frac_n;
  logic          nf_stop_q, nf_stop_d, nf_stop_n;
  logic [16:0]   ip_q, ip_d, ip_n;

  logic [4:0]    cv;
  logic [7:0]    cb [5];

  function automatic logic kern_hit(input logic act, input logic neg, input logic frac,
                                    input logic [16:0] ip, input logic [15:0] thr);
    return act && neg && ((ip > {1'b0, thr}) || ((ip == {1'b0, thr}) && frac));
  endfunction

  // Byte decode: handle one byte, then fold in the end-of-stream flush
  always_comb begin
    logic [7:0]  c;
    logic [4:0]  hx;
    logic        hex_go;
    logic        hex_has;
    logic        take;
    logic [7:0]  ov_t;
    logic [NW-1:0] nest_t;
    logic [19:0] acc_num;
    logic        open;

    c       = in_byte_i;
    hx      = hex_val(c);
    hex_go  = 1'b0;
    hex_has = hv_q;
    take    = 1'b1;
    ov_t    = {ov_q[4:0], c[2:0]};
    nest_t  = nest_q;
    acc_num = 20'(({3'd0, ip_q} << 3) + ({3'd0, ip_q} << 1) + {16'd0, c[3:0]});
    open    = 1'b0;

    mode_n = mode_q; in_arr_n = in_arr_q; nest_n = nest_q; esc_n = esc_q;
    oc_n = oc_q; ov_n = ov_q; hv_n = hv_q; hn_n = hn_q;
    nf_act_n = nf_act_q; nf_neg_n = nf_neg_q; nf_dot_n = nf_dot_q;
    nf_frac_n = nf_frac_q; nf_stop_n = nf_stop_q; ip_n = ip_q;

    cv = '0;
    for (int i = 0; i < 5; i++) cb[i] = CH_SPACE;

    unique case (mode_q)
      MODE_LIT: begin
        if (esc_q) begin
          esc_n = 1'b0;
          if (is_octal(c)) begin
            oc_n = 2'd1;
            ov_n = {5'd0, c[2:0]};
          end else begin
            cv[1] = 1'b1;
            priority case (c)
              CH_N:    cb[1] = CH_LF;
              CH_R:    cb[1] = CH_CR;
              CH_T:    cb[1] = CH_TAB;
              default: cb[1] = c;
            endcase
          end
        end else begin
          if (oc_q != 2'd0) begin
            if (is_octal(c)) begin
              take = 1'b0;
              if (oc_q == 2'd2) begin
                cv[1] = 1'b1;
                cb[1] = ov_t;
                oc_n  = 2'd0;
                ov_n  = 8'd0;
              end else begin
                oc_n = 2'(oc_q + 2'd1);
                ov_n = ov_t;
              end
            end else begin
              cv[0] = 1'b1;
              cb[0] = ov_q;
              oc_n  = 2'd0;
              ov_n  = 8'd0;
            end
          end
          if (take) begin
            if (c == CH_BSLASH) begin
              esc_n = 1'b1;
            end else if (c == CH_LPAREN) begin
              if (nest_q < NEST_MAX) nest_n = NW'(nest_q + NEST_ONE);
              cv[1] = 1'b1;
              cb[1] = CH_LPAREN;
            end else if (c == CH_RPAREN) begin
              if (nest_q != '0) nest_t = NW'(nest_q - NEST_ONE);
              nest_n = nest_t;
              if (nest_t != '0) begin
                cv[1] = 1'b1;
                cb[1] = CH_RPAREN;
              end else begin
                mode_n = MODE_IDLE;
                cv[1]  = !in_arr_q;
              end
            end else begin
              cv[1] = 1'b1;
              cb[1] = c;
            end
          end
        end
      end
      MODE_HEX: begin
        hex_go = 1'b1;
      end
      MODE_LT: begin
        // a second '<' just keeps the pending state
        if (c != CH_LT) begin
          hex_go  = 1'b1;
          hex_has = 1'b0;
          mode_n  = MODE_HEX;
        end
      end
      MODE_IDLE: begin
        if (in_arr_q) begin
          if (nf_act_q) begin
            if (is_digit(c)) begin
              take = 1'b0;
              if (!nf_stop_q) begin
                if (nf_dot_q) begin
                  if (c != CH_ZERO) nf_frac_n = 1'b1;
                end else begin
                  ip_n = (acc_num > {3'd0, INT_SAT}) ? INT_SAT : acc_num[16:0];
                end
              end
            end else if (c == CH_DOT) begin
              take = 1'b0;
              if (nf_dot_q) nf_stop_n = 1'b1;
              else nf_dot_n = 1'b1;
            end else begin
              cv[0] = kern_hit(nf_act_q, nf_neg_q, nf_frac_q, ip_q, kern_thr_q);
              nf_act_n = 1'b0; nf_neg_n = 1'b0; nf_dot_n = 1'b0;
              nf_frac_n = 1'b0; nf_stop_n = 1'b0; ip_n = '0;
            end
          end
          if (take) begin
            if (c == CH_RBRACK) begin
              in_arr_n = 1'b0;
              cv[1]    = 1'b1;
            end else if (c == CH_LPAREN) begin
              mode_n = MODE_LIT;
              nest_n = NEST_ONE;
            end else if (c == CH_MINUS) begin
              nf_act_n = 1'b1; nf_neg_n = 1'b1; ip_n = '0;
            end else if (is_digit(c)) begin
              nf_act_n = 1'b1;
              ip_n     = {13'd0, c[3:0]};
            end else if (c == CH_DOT) begin
              nf_act_n = 1'b1; nf_dot_n = 1'b1; ip_n = '0;
            end
          end
        end else begin
          if (c == CH_LBRACK) begin
            in_arr_n = 1'b1;
          end else if (c == CH_LPAREN) begin
            mode_n = MODE_LIT;
            nest_n = NEST_ONE;
          end else if (c == CH_LT) begin
            mode_n = MODE_LT;
          end
        end
      end
      default: ;
    endcase

    if (hex_go) begin
      if (c == CH_GT) begin
        mode_n = MODE_IDLE;
        hv_n   = 1'b0;
        cv[1]  = 1'b1;
      end else if (hx[4]) begin
        if (hex_has) begin
          cv[1] = 1'b1;
          cb[1] = {hn_q, hx[3:0]};
          hv_n  = 1'b0;
        end else begin
          hv_n = 1'b1;
          hn_n = hx[3:0];
        end
      end else begin
        hv_n = hex_has;
      end
    end

    // drop NUL bytes
    for (int i = 0; i < 2; i++) if (cb[i] == 8'd0) cv[i] = 1'b0;

    if (stream_end_i) begin
      cv[2] = kern_hit(nf_act_n, nf_neg_n, nf_frac_n, ip_n, kern_thr_q);
      cv[3] = (mode_n == MODE_LIT) && (oc_n != 2'd0) && (ov_n != 8'd0);
      cb[3] = ov_n;
      open  = (mode_n == MODE_LIT) || (mode_n == MODE_HEX) || in_arr_n;
      cv[4] = open;
    end
  end

  // Keep the first two candidates in order
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    push_o = '0;
    for (int i = 0; i < 5; i++) begin
      if (cv[i]) begin
        if (n == 2'd0) push_o.b0 = cb[i];
        else if (n == 2'd1) push_o.b1 = cb[i];
        if (n != 2'd2) n = 2'(n + 2'd1);
      end
    end
    push_o.num = acc_i ? n : 2'd0;
  end

  always_comb begin
    if (stream_end_i) begin
      mode_d = MODE_IDLE; in_arr_d = 1'b0; nest_d = '0; esc_d = 1'b0;
      oc_d = 2'd0; ov_d = 8'd0; hv_d = 1'b0; hn_d = 4'd0;
      nf_act_d = 1'b0; nf_neg_d = 1'b0; nf_dot_d = 1'b0;
      nf_frac_d = 1'b0; nf_stop_d = 1'b0; ip_d = '0;
    end else begin
      mode_d = mode_n; in_arr_d = in_arr_n; nest_d = nest_n; esc_d = esc_n;
      oc_d = oc_n; ov_d = ov_n; hv_d = hv_n; hn_d = hn_n;
      nf_act_d = nf_act_n; nf_neg_d = nf_neg_n; nf_dot_d = nf_dot_n;
      nf_frac_d = nf_frac_n; nf_stop_d = nf_stop_n; ip_d = ip_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_thr_q <= KERN_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      kern_thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; in_arr_q <= 1'b0; nest_q <= '0; esc_q <= 1'b0;
      oc_q <= 2'd0; ov_q <= 8'd0; hv_q <= 1'b0; hn_q <= 4'd0;
      nf_act_q <= 1'b0; nf_neg_q <= 1'b0; nf_dot_q <= 1'b0;
      nf_frac_q <= 1'b0; nf_stop_q <= 1'b0; ip_q <= '0;
    end else if (acc_i) begin
      mode_q <= mode_d; in_arr_q <= in_arr_d; nest_q <= nest_d; esc_q <= esc_d;
      oc_q <= oc_d; ov_q <= ov_d; hv_q <= hv_d; hn_q <= hn_d;
      nf_act_q <= nf_act_d; nf_neg_q <= nf_neg_d; nf_dot_q <= nf_dot_d;
      nf_frac_q <= nf_frac_d; nf_stop_q <= nf_stop_d; ip_q <= ip_d;
    end
  end

  a_nest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q <= NEST_MAX) else $error("nest depth above limit");

  a_lit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_q || oc_q != 2'd0) |-> (mode_q == MODE_LIT))
    else $error("escape state outside literal string");

  a_hex_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> (mode_q == MODE_HEX)) else $error("hex nibble outside hex string");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && stream_end_i) |=> (mode_q == MODE_IDLE && !in_arr_q && !nf_act_q))
    else $error("parser not idle after stream end");

endmodule

### rtl/core/pdftx_out_fifo.sv
// ----------------------------------------------------------------------------
// pdftx_out_fifo
// Small result queue: takes up to two text bytes per cycle, hands out one.
// ----------------------------------------------------------------------------
module pdftx_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdftx_pkg::push_t  push_i,
  output logic              room_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [7:0]        m_data_o,
  output logic              m_last_o
);
  import pdftx_pkg::*;

  logic [8:0]         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [FIFO_AW-1:0] wr_nxt;

  assign pop       = m_valid_o && m_ready_i;
  assign m_valid_o = (cnt_q != '0);
  assign {m_last_o, m_data_o} = mem_q[rd_q];
  // room for a worst-case request of two bytes
  assign room_o    = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_nxt    = FIFO_AW'(wr_q + 1'b1);

  always_comb begin
    wr_d  = FIFO_AW'(wr_q + FIFO_AW'(push_i.num));
    rd_d  = pop ? FIFO_AW'(rd_q + 1'b1) : rd_q;
    cnt_d = FIFO_CW'(cnt_q + FIFO_CW'(push_i.num) - FIFO_CW'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= {push_i.num == 2'd1, push_i.b0};
    if (push_i.num == 2'd2) mem_q[wr_nxt] <= {1'b1, push_i.b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH)) else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> (cnt_q + FIFO_CW'(push_i.num) <= FIFO_CW'(FIFO_DEPTH)))
    else $error("queue written without room");

  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2 && !pop) |=> (cnt_q == FIFO_CW'($past(cnt_q) + 2'd2)))
    else $error("double push lost an entry");

endmodule

### rtl/core/pdf_text_operator_extractor_unit.sv
// ----------------------------------------------------------------------------
// pdf_text_operator_extractor_unit
// Extracts text bytes from a PDF content stream, one stream byte per cycle
// while the result queue has room.
//  Port group   Dir  Payload                    Notes
//  s_axis       in   tdata[7:0]=in_byte         tlast = stream_end
//  m_axis       out  tdata[7:0]=text_byte       tlast = run_last
//  cfg          in   wdata[15:0]=kern_threshold write on cfg_we_i
//
//  One stream byte per cycle; the decode of a byte is one pass of logic
//  between the parser state registers and a four-entry result queue.
//  A byte that yields two text bytes drains as two output beats, so the
//  sustained input rate is set by the output side at one text byte a cycle.
//  s_axis_tready_o drops while the queue cannot take two more bytes.
//  Reset returns the parser to idle and the kern threshold to 120.
// ----------------------------------------------------------------------------
module pdf_text_operator_extractor_unit #(
  parameter int unsigned MaxNestDepth = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] text_byte
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import pdftx_pkg::*;

  logic  acc;
  push_t push;

  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  pdftx_parser #(
    .MaxNestDepth(MaxNestDepth)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .in_byte_i    (s_axis_tdata_i),
    .stream_end_i (s_axis_tlast_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_o       (push)
  );

  pdftx_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

### sim/tb_pdf_text_operator_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pdf_text_operator_extractor_unit
// Self-checking bench for the PDF text extractor. Content stream bytes go in
// on s_axis. A parser model in the bench predicts every text byte and its
// tlast. The results on m_axis are checked in order. Both sides idle at
// random, and the kern threshold is swept between phases.
// ----------------------------------------------------------------------------
module tb_pdf_text_operator_extractor_unit;
  import pdftx_pkg::*;

  localparam int unsigned NestLimit   = 255;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned IdleMax     = 13;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] in_byte
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [7:0] text_byte
  logic        m_axis_tlast_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  pdf_text_operator_extractor_unit #(
    .MaxNestDepth(NestLimit)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Parser model state
  logic [1:0]  ps_mode;
  logic        ps_in_array;
  logic [7:0]  ps_depth;
  logic        ps_escape;
  logic [1:0]  ps_oct_cnt;
  logic [7:0]  ps_oct_val;
  logic [4:0]  ps_hex_hi;
  logic        kn_active;
  logic        kn_neg;
  logic        kn_dot;
  logic        kn_frac;
  logic        kn_stop;
  logic [16:0] kn_int;
  logic [15:0] kern_thr;

  logic [7:0]  step_text[$];
  text_beat_t  text_expected_q[$];

  int          error_count;
  int unsigned stream_items;
  int unsigned cycle_count;
  int unsigned src_idle_max;
  int unsigned snk_idle_max;

  function automatic bit dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit oct_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // NUL never leaves the block; at most two bytes per request
  function automatic void emit_text(input logic [7:0] c);
    if (c != 8'h00 && step_text.size() < 2) step_text.push_back(c);
  endfunction

  function automatic void reset_parser();
    ps_mode     = MODE_IDLE;
    ps_in_array = 1'b0;
    ps_depth    = '0;
    ps_escape   = 1'b0;
    ps_oct_cnt  = '0;
    ps_oct_val  = '0;
    ps_hex_hi   = '0;
    kn_active   = 1'b0;
    kn_neg      = 1'b0;
    kn_dot      = 1'b0;
    kn_frac     = 1'b0;
    kn_stop     = 1'b0;
    kn_int      = '0;
  endfunction

  function automatic void close_kern_number();
    if (kn_active && kn_neg &&
        (kn_int > {1'b0, kern_thr} || (kn_int == {1'b0, kern_thr} && kn_frac)))
      emit_text(CH_SPACE);
    kn_active = 1'b0;
    kn_neg    = 1'b0;
    kn_dot    = 1'b0;
    kn_frac   = 1'b0;
    kn_stop   = 1'b0;
    kn_int    = '0;
  endfunction

  function automatic void literal_char(input logic [7:0] c);
    if (ps_escape) begin
      ps_escape = 1'b0;
      if (oct_digit(c)) begin
        ps_oct_cnt = 2'd1;
        ps_oct_val = c - CH_ZERO;
      end else if (c == CH_N) emit_text(CH_LF);
      else if (c == CH_R) emit_text(CH_CR);
      else if (c == CH_T) emit_text(CH_TAB);
      else emit_text(c);
      return;
    end
    if (ps_oct_cnt != 2'd0) begin
      if (oct_digit(c)) begin
        ps_oct_val = {ps_oct_val[4:0], 3'b000} + (c - CH_ZERO);
        ps_oct_cnt = ps_oct_cnt + 2'd1;
        if (ps_oct_cnt == 2'd3) begin
          emit_text(ps_oct_val);
          ps_oct_cnt = '0;
          ps_oct_val = '0;
        end
        return;
      end
      // a short octal escape ends here, then the byte is parsed as usual
      emit_text(ps_oct_val);
      ps_oct_cnt = '0;
      ps_oct_val = '0;
    end
    if (c == CH_BSLASH) begin
      ps_escape = 1'b1;
    end else if (c == CH_LPAREN) begin
      if (ps_depth < NestLimit) ps_depth = ps_depth + 8'd1;
      emit_text(CH_LPAREN);
    end else if (c == CH_RPAREN) begin
      if (ps_depth > 0) ps_depth = ps_depth - 8'd1;
      if (ps_depth > 0) begin
        emit_text(CH_RPAREN);
      end else begin
        ps_mode = MODE_IDLE;
        if (!ps_in_array) emit_text(CH_SPACE);
      end
    end else begin
      emit_text(c);
    end
  endfunction

  function automatic void hex_char(input logic [7:0] c);
    int d;
    if (c == CH_GT) begin
      ps_mode   = MODE_IDLE;
      ps_hex_hi = '0;
      emit_text(CH_SPACE);
      return;
    end
    d = hex_nibble(c);
    if (d < 0) return;
    if (ps_hex_hi[4]) begin
      emit_text({ps_hex_hi[3:0], d[3:0]});
      ps_hex_hi = '0;
    end else begin
      ps_hex_hi = {1'b1, d[3:0]};
    end
  endfunction

  function automatic void array_char(input logic [7:0] c);
    int unsigned acc;
    if (kn_active) begin
      if (dec_digit(c)) begin
        if (!kn_stop) begin
          if (kn_dot) begin
            if (c != CH_ZERO) kn_frac = 1'b1;
          end else begin
            acc = {15'd0, kn_int} * 32'd10 + {24'd0, c - CH_ZERO};
            if (acc > INT_SAT) acc = 32'(INT_SAT);
            kn_int = acc[16:0];
          end
        end
        return;
      end
      if (c == CH_DOT) begin
        if (kn_dot) kn_stop = 1'b1;
        else kn_dot = 1'b1;
        return;
      end
      close_kern_number();
    end
    if (c == CH_RBRACK) begin
      ps_in_array = 1'b0;
      emit_text(CH_SPACE);
    end else if (c == CH_LPAREN) begin
      ps_mode  = MODE_LIT;
      ps_depth = 8'd1;
    end else if (c == CH_MINUS) begin
      kn_active = 1'b1;
      kn_neg    = 1'b1;
      kn_int    = '0;
    end else if (dec_digit(c)) begin
      kn_active = 1'b1;
      kn_int    = {9'd0, c - CH_ZERO};
    end else if (c == CH_DOT) begin
      kn_active = 1'b1;
      kn_dot    = 1'b1;
      kn_int    = '0;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (ps_mode)
      MODE_LIT: literal_char(c);
      MODE_HEX: hex_char(c);
      MODE_LT: begin
        // drop a doubled '<' and judge the next byte
        if (c != CH_LT) begin
          ps_mode   = MODE_HEX;
          ps_hex_hi = '0;
          hex_char(c);
        end
      end
      default: begin
        if (ps_in_array) array_char(c);
        else if (c == CH_LBRACK) ps_in_array = 1'b1;
        else if (c == CH_LPAREN) begin
          ps_mode  = MODE_LIT;
          ps_depth = 8'd1;
        end else if (c == CH_LT) ps_mode = MODE_LT;
      end
    endcase
  endfunction

  function automatic void predict_text(input logic [7:0] c, input logic last);
    bit open;
    step_text.delete();
    parse_char(c);
    if (last) begin
      if (kn_active) close_kern_number();
      if (ps_mode == MODE_LIT && ps_oct_cnt != 2'd0) emit_text(ps_oct_val);
      open = (ps_mode == MODE_LIT) || (ps_mode == MODE_HEX) || ps_in_array;
      if (open) emit_text(CH_SPACE);
      reset_parser();
    end
    foreach (step_text[k])
      text_expected_q.push_back('{ch: step_text[k], last: (k == step_text.size() - 1)});
  endfunction

  // Predict on every accepted request, then check every accepted result
  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_text(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (text_expected_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("unexpected text byte: got %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          want = text_expected_q.pop_front();
          if (m_axis_tdata_o !== want.ch || m_axis_tlast_o !== want.last) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("text byte mismatch: expected %h last %b, got %h last %b",
                       want.ch, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("pdf_text_operator_extractor_unit verification failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each result
  initial begin
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (snk_idle_max == 0) ? 0 : $urandom_range(0, snk_idle_max);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Hold tvalid after acceptance; the next request lowers it or replaces it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (src_idle_max == 0) ? 0 : $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    stream_items++;
  endtask

  task automatic send_chars(input string s, input bit end_stream);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_stream && (i == s.len() - 1));
  endtask

  // Random stream end on roughly one byte in 64
  task automatic send_stream(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 63) == 0);
  endtask

  task automatic set_kern_threshold(input logic [15:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (text_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    kern_thr = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic gen_literal(input int unsigned body_len);
    logic [7:0] b;
    int unsigned open;
    open = 0;
    send_stream(CH_LPAREN);
    repeat (body_len) begin
      case ($urandom_range(0, 15))
        6: begin
          send_stream(CH_LPAREN);
          open++;
        end
        7: begin
          if (open > 0) begin
            send_stream(CH_RPAREN);
            open--;
          end
        end
        8, 9: begin
          send_stream(CH_BSLASH);
          case ($urandom_range(0, 5))
            0: send_stream(CH_N);
            1: send_stream(CH_R);
            2: send_stream(CH_T);
            3: send_stream(CH_LPAREN);
            4: send_stream(CH_RPAREN);
            default: send_stream(CH_BSLASH);
          endcase
        end
        10: begin
          send_stream(CH_BSLASH);
          send_stream(8'($urandom_range(0, 255)));
        end
        11, 12: begin
          send_stream(CH_BSLASH);
          repeat ($urandom_range(1, 3)) send_stream(8'($urandom_range(CH_ZERO, CH_SEVEN)));
        end
        13: send_stream(8'h00);
        default: begin
          do b = 8'($urandom_range(1, 255));
          while (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSLASH);
          send_stream(b);
        end
      endcase
    end
    repeat (open) send_stream(CH_RPAREN);
    send_stream(CH_RPAREN);
  endtask

  task automatic gen_hex_string();
    string hex_chars;
    logic [7:0] b;
    hex_chars = "0123456789abcdefABCDEF";
    send_stream(CH_LT);
    if ($urandom_range(0, 3) == 0) send_stream(CH_LT);
    repeat ($urandom_range(0, 9)) begin
      if ($urandom_range(0, 5) == 0) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_GT);
        send_stream(b);
      end else begin
        send_stream(hex_chars[$urandom_range(0, 21)]);
      end
    end
    send_stream(CH_GT);
  endtask

  // Kern values cluster around the threshold to hit both sides of the compare
  task automatic gen_kern_number();
    int unsigned mag;
    string digits;
    if ($urandom_range(0, 3) != 0) send_stream(CH_MINUS);
    case ($urandom_range(0, 5))
      0: mag = (kern_thr == 0) ? 0 : kern_thr - 1;
      1: mag = 32'(kern_thr);
      2: mag = kern_thr + 1;
      3: mag = $urandom_range(0, 999);
      default: mag = $urandom_range(0, 200000);
    endcase
    if ($urandom_range(0, 7) != 0) begin
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++) send_stream(digits[i]);
    end
    if ($urandom_range(0, 1) == 1) begin
      send_stream(CH_DOT);
      repeat ($urandom_range(0, 3))
        send_stream(8'(($urandom_range(0, 2) == 0) ? CH_ZERO :
                       $urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(0, 5) == 0) begin
        send_stream(CH_DOT);
        send_stream(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    end
  endtask

  task automatic gen_tj_array();
    string junk;
    junk = "<[>TJ*";
    send_stream(CH_LBRACK);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: gen_literal($urandom_range(0, 5));
        3, 4, 5: gen_kern_number();
        6: send_stream(CH_SPACE);
        default: send_stream(junk[$urandom_range(0, 5)]);
      endcase
    end
    send_stream(CH_RBRACK);
  endtask

  task automatic test_hex_strings();
    // doubled '<', one byte pair, then a lone nibble before '>'
    send_chars("<<4A1>", 1'b0);
  endtask

  task automatic test_literal_escapes();
    // octal of three digits, short octal ended by a letter, nesting, \n
    send_chars("(\\101\\7z(\\n))", 1'b0);
  endtask

  task automatic test_kern_array();
    send_chars("[-121(x)]", 1'b0);
  endtask

  task automatic test_stream_end();
    // end inside a kern number in an array: kern space plus closing space
    send_chars("[-200", 1'b1);
    // top byte value, then NUL on the stream end inside a string
    send_chars("(", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_deep_nesting();
    repeat (NestLimit + 3) send_byte(CH_LPAREN, 1'b0);
    send_byte("k", 1'b0);
    repeat (4) send_byte(CH_RPAREN, 1'b0);
    send_byte("z", 1'b1);
  endtask

  task automatic test_random_streams(input int unsigned count);
    int unsigned target;
    target = stream_items + count;
    while (stream_items < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gen_literal($urandom_range(0, 12));
        3, 4: gen_hex_string();
        5, 6, 7: gen_tj_array();
        8: repeat ($urandom_range(1, 4)) send_stream(8'($urandom_range(0, 255)));
        default: send_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    reset_parser();
    kern_thr     = KERN_THRESHOLD_RST;
    error_count  = 0;
    stream_items = 0;
    cycle_count  = 0;
    src_idle_max = 0;
    snk_idle_max = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_hex_strings();
    test_literal_escapes();
    test_kern_array();
    test_stream_end();

    src_idle_max = IdleMax;
    snk_idle_max = IdleMax;
    test_random_streams(270);

    set_kern_threshold(16'h0000);
    src_idle_max = 0;
    snk_idle_max = 0;
    test_random_streams(220);

    set_kern_threshold(16'hFFFF);
    src_idle_max = IdleMax;
    snk_idle_max = 0;
    test_random_streams(190);
    test_deep_nesting();

    set_kern_threshold(16'($urandom_range(1, 300)));
    src_idle_max = 0;
    snk_idle_max = IdleMax;
    test_random_streams(220);

    set_kern_threshold(16'($urandom_range(0, 65535)));
    src_idle_max = IdleMax;
    snk_idle_max = IdleMax;
    test_random_streams(150);

    set_kern_threshold(KERN_THRESHOLD_RST);
    test_random_streams(200);

    s_axis_tvalid_i <= 1'b0;
    while (text_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pdf_text_operator_extractor_unit verification clean");
    end else begin
      $display("pdf_text_operator_extractor_unit verification failed");
    end
    $finish;
  end

endmodule
